FILE: hdl/gvn_pkg.sv
`timescale 1ns / 1ps
package gvn_pkg;

   localparam int GVN_MAX_ROWS   = 64;
   localparam int GVN_MAX_COLS   = 64;
   localparam int GVN_COORD_BITS = 16;

   localparam int POS_W      = 16;
   localparam int NORM_W     = 16;
   localparam int IDX_W      = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam int CNT_W      = 6;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS = 1'b1;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // last counter values of the sequenced phases
   localparam logic [CNT_W-1:0] READ_LAST = CNT_W'(8);
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(30);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(14);

   typedef enum logic [3:0] {
      SEL_CENTER, SEL_UP, SEL_DN, SEL_RT, SEL_LF,
      SEL_D0, SEL_D1, SEL_D2, SEL_D3
   } vsel_type;

   typedef enum logic [1:0] {QD_RT_DN, QD_DN_LF, QD_LF_UP, QD_UP_RT} quad_type;
   typedef enum logic [1:0] {TERM_EDGES, TERM_E1_DIAG, TERM_DIAG_E2} term_type;
   typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_READ, ST_READ_WAIT, ST_CROSS, ST_CROSS_WAIT,
      ST_NORM_INIT, ST_SHIFT, ST_SQUARE, ST_SQSUM, ST_SQRT_INIT, ST_SQRT,
      ST_DIV_INIT, ST_DIV, ST_FINISH
   } state_type;

   typedef struct packed {
      logic     accept;
      logic     ram_write;
      logic     rd_issue;
      vsel_type rd_sel;
      logic     cross_issue;
      quad_type quad;
      term_type term;
      axis_type axis;
      logic     norm_init;
      logic     shift_step;
      logic     sq_mul;
      logic     sq_sum;
      logic     sqrt_init;
      logic     sqrt_step;
      logic     div_init;
      logic     div_step;
      logic     out_load;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic is_query;
      logic mag_zero;
      logic norm_done;
      logic out_free;
   } sts_type;

endpackage

FILE: hdl/gvn_if.sv
`timescale 1ns / 1ps
interface gvn_req_if import gvn_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    req_type;
   logic [IDX_W-1:0]        row_index;
   logic [IDX_W-1:0]        col_index;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;

   modport source (output valid, req_type, row_index, col_index, pos_x, pos_y, pos_z,
                   input ready);
   modport sink (input valid, req_type, row_index, col_index, pos_x, pos_y, pos_z,
                 output ready);
endinterface

interface gvn_rsp_if import gvn_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [NORM_W-1:0] norm_x;
   logic signed [NORM_W-1:0] norm_y;
   logic signed [NORM_W-1:0] norm_z;
   logic                     degenerate;
   logic                     range_error;

   modport source (output valid, norm_x, norm_y, norm_z, degenerate, range_error,
                   input ready);
   modport sink (input valid, norm_x, norm_y, norm_z, degenerate, range_error,
                 output ready);
endinterface

FILE: hdl/grid_vertex_normal_engine.sv
`timescale 1ns / 1ps
// Load or out-of-range request: dispatch, then finish once the output is free, then back to idle.
// Query: result follows the 9 reads, the 36-step cross-product sequence, a normalizing shift of
//   0..29 steps, the squaring, the 31-step sqrt and 15-step divide, and waits for a free output.
//   A zero sum skips the rest and goes straight to the result.
// One request in flight; a new request is taken while the previous result waits.
// Reset (synchronous, active high) sets grid_rows = grid_cols = 1 and empties the pipeline.
module grid_vertex_normal_engine import gvn_pkg::*; #(
   parameter int MAX_ROWS   = GVN_MAX_ROWS,
   parameter int MAX_COLS   = GVN_MAX_COLS,
   parameter int COORD_BITS = GVN_COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   gvn_req_if.sink               req_bus,
   gvn_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;

   // sequencer: accept, read nine vertices, cross sums, normalize, respond
   // the vertex store is not cleared by reset and must be loaded before it is queried
   gvn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: vertex store, difference regs, shared multipliers, sqrt and dividers
   gvn_dp #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_type    (req_bus.req_type),
      .row_index   (req_bus.row_index),
      .col_index   (req_bus.col_index),
      .pos_x       (req_bus.pos_x),
      .pos_y       (req_bus.pos_y),
      .pos_z       (req_bus.pos_z),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .norm_x      (rsp_bus.norm_x),
      .norm_y      (rsp_bus.norm_y),
      .norm_z      (rsp_bus.norm_z),
      .degenerate  (rsp_bus.degenerate),
      .range_error (rsp_bus.range_error)
   );
endmodule

FILE: hdl/gvn_ram.sv
`timescale 1ns / 1ps
module gvn_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4096,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/gvn_ctrl.sv
`timescale 1ns / 1ps
module gvn_ctrl import gvn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   quad_type         quad_ff, quad_in;
   term_type         term_ff, term_in;
   axis_type         axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         quad_ff  <= QD_RT_DN;
         term_ff  <= TERM_EDGES;
         axis_ff  <= AX_X;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         quad_ff  <= quad_in;
         term_ff  <= term_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      quad_in   = quad_ff;
      term_in   = term_ff;
      axis_in   = axis_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rd_sel = vsel_type'(cnt_ff[3:0]);
      cmd.quad   = quad_ff;
      cmd.term   = term_ff;
      cmd.axis   = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            cnt_in = '0;
            if (!sts.in_range) begin
               state_in = ST_FINISH;
            end else if (!sts.is_query) begin
               cmd.ram_write = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            if (cnt_ff == READ_LAST) begin
               state_in = ST_READ_WAIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_READ_WAIT: begin
            quad_in  = QD_RT_DN;
            term_in  = TERM_EDGES;
            axis_in  = AX_X;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            cmd.cross_issue = 1'b1;
            if (axis_ff == AX_Z) begin
               axis_in = AX_X;
               if (term_ff == TERM_DIAG_E2) begin
                  term_in = TERM_EDGES;
                  if (quad_ff == QD_UP_RT) begin
                     state_in = ST_CROSS_WAIT;
                  end else begin
                     quad_in = quad_type'(quad_ff + 1'b1);
                  end
               end else begin
                  term_in = term_type'(term_ff + 1'b1);
               end
            end else begin
               axis_in = axis_type'(axis_ff + 1'b1);
            end
         end
         ST_CROSS_WAIT: begin
            state_in = ST_NORM_INIT;
         end
         ST_NORM_INIT: begin
            cmd.norm_init = 1'b1;
            state_in      = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (sts.mag_zero) begin
               state_in = ST_FINISH;
            end else if (sts.norm_done) begin
               state_in = ST_SQUARE;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         ST_SQUARE: begin
            cmd.sq_mul = 1'b1;
            state_in   = ST_SQSUM;
         end
         ST_SQSUM: begin
            cmd.sq_sum = 1'b1;
            state_in   = ST_SQRT_INIT;
         end
         ST_SQRT_INIT: begin
            cmd.sqrt_init = 1'b1;
            cnt_in        = '0;
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == SQRT_LAST) begin
               state_in = ST_DIV_INIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

FILE: hdl/gvn_dp.sv
`timescale 1ns / 1ps
module gvn_dp import gvn_pkg::*; #(
   parameter int MAX_ROWS   = GVN_MAX_ROWS,
   parameter int MAX_COLS   = GVN_MAX_COLS,
   parameter int COORD_BITS = GVN_COORD_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic                     req_type,
   input  logic [IDX_W-1:0]         row_index,
   input  logic [IDX_W-1:0]         col_index,
   input  logic signed [POS_W-1:0]  pos_x,
   input  logic signed [POS_W-1:0]  pos_y,
   input  logic signed [POS_W-1:0]  pos_z,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [NORM_W-1:0] norm_x,
   output logic signed [NORM_W-1:0] norm_y,
   output logic signed [NORM_W-1:0] norm_z,
   output logic                     degenerate,
   output logic                     range_error
);
   localparam int CB    = COORD_BITS;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int DW    = CB + 1;
   localparam int PW    = 2 * DW;
   localparam int ACC_W = PW + 5;              // twelve cross terms
   localparam int MW    = (ACC_W > 31) ? ACC_W : 31;
   localparam int SQ_W  = 63;
   localparam int LEN_W = 31;
   localparam int NUM_W = 45;
   localparam int Q_W   = 15;

   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [DW-1:0] z;
   } vec_type;

   // ---------------- request and configuration registers
   logic                 type_ff;
   logic [IDX_W-1:0]     row_ff, col_ff;
   logic signed [CB-1:0] px_ff, py_ff, pz_ff;
   logic [CSR_DATA_W-1:0] rows_ff, cols_ff;
   logic signed [23:0]   px_ext, py_ext, pz_ext;
   logic [CSR_DATA_W-1:0] rows_in, cols_in;

   assign px_ext = 24'(pos_x);
   assign py_ext = 24'(pos_y);
   assign pz_ext = 24'(pos_z);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         type_ff <= req_type;
         row_ff  <= row_index;
         col_ff  <= col_index;
         px_ff   <= px_ext[CB-1:0];
         py_ff   <= py_ext[CB-1:0];
         pz_ff   <= pz_ext[CB-1:0];
      end
   end

   // zero acts as one, oversize saturates
   always_comb begin
      rows_in = csr_wdata;
      cols_in = csr_wdata;
      if (csr_wdata == '0) begin
         rows_in = CSR_DATA_W'(1);
         cols_in = CSR_DATA_W'(1);
      end else begin
         if (int'(csr_wdata) > MAX_ROWS) rows_in = CSR_DATA_W'(MAX_ROWS);
         if (int'(csr_wdata) > MAX_COLS) cols_in = CSR_DATA_W'(MAX_COLS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CSR_DATA_W'(1);
         cols_ff <= CSR_DATA_W'(1);
      end else if (csr_wr_en) begin
         if (csr_index == REG_GRID_ROWS) rows_ff <= rows_in;
         if (csr_index == REG_GRID_COLS) cols_ff <= cols_in;
      end
   end

   logic in_range, has_up, has_dn, has_rt, has_lf;
   logic [CSR_DATA_W-1:0] row_w, col_w;

   assign row_w    = {1'b0, row_ff};
   assign col_w    = {1'b0, col_ff};
   assign in_range = (row_w < rows_ff) && (col_w < cols_ff);
   assign has_up   = (row_w + 1'b1) < rows_ff;
   assign has_dn   = row_ff != '0;
   assign has_rt   = (col_w + 1'b1) < cols_ff;
   assign has_lf   = col_ff != '0;

   // ---------------- vertex store access
   logic [AW-1:0]       base_addr, rd_addr;
   logic [CSR_DATA_W-1:0] nb_row, nb_col;
   logic                nb_ok;
   logic [3*CB-1:0]     rd_data;

   assign base_addr = AW'(int'(row_ff) * MAX_COLS + int'(col_ff));

   always_comb begin
      nb_row = row_w;
      nb_col = col_w;
      nb_ok  = 1'b1;
      case (cmd.rd_sel)
         SEL_CENTER: nb_ok = 1'b1;
         SEL_UP: begin nb_row = row_w + 1'b1; nb_ok = has_up; end
         SEL_DN: begin nb_row = row_w - 1'b1; nb_ok = has_dn; end
         SEL_RT: begin nb_col = col_w + 1'b1; nb_ok = has_rt; end
         SEL_LF: begin nb_col = col_w - 1'b1; nb_ok = has_lf; end
         SEL_D0: begin
            nb_row = row_w - 1'b1; nb_col = col_w + 1'b1; nb_ok = has_dn && has_rt;
         end
         SEL_D1: begin
            nb_row = row_w - 1'b1; nb_col = col_w - 1'b1; nb_ok = has_dn && has_lf;
         end
         SEL_D2: begin
            nb_row = row_w + 1'b1; nb_col = col_w - 1'b1; nb_ok = has_up && has_lf;
         end
         SEL_D3: begin
            nb_row = row_w + 1'b1; nb_col = col_w + 1'b1; nb_ok = has_up && has_rt;
         end
         default: nb_ok = 1'b0;
      endcase
      // a missing neighbor reads the center, so its difference is zero
      rd_addr = nb_ok ? AW'(int'(nb_row) * MAX_COLS + int'(nb_col)) : base_addr;
   end

   gvn_ram #(.WIDTH(3 * CB), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (cmd.ram_write),
      .wr_addr (base_addr),
      .wr_data ({px_ff, py_ff, pz_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------- neighbor differences
   logic                 rd_vld_ff;
   vsel_type             rd_sel_ff;
   logic signed [CB-1:0] ctr_x_ff, ctr_y_ff, ctr_z_ff;
   logic signed [CB-1:0] rd_x, rd_y, rd_z;
   vec_type              dvec;
   vec_type              up_ff, dn_ff, rt_ff, lf_ff;
   vec_type              dg_ff [4];

   assign rd_x = rd_data[3*CB-1:2*CB];
   assign rd_y = rd_data[2*CB-1:CB];
   assign rd_z = rd_data[CB-1:0];
   assign dvec.x = DW'(rd_x) - DW'(ctr_x_ff);
   assign dvec.y = DW'(rd_y) - DW'(ctr_y_ff);
   assign dvec.z = DW'(rd_z) - DW'(ctr_z_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_issue;
      end
   end

   always_ff @(posedge clock) begin
      rd_sel_ff <= cmd.rd_sel;
      if (rd_vld_ff) begin
         case (rd_sel_ff)
            SEL_CENTER: begin
               ctr_x_ff <= rd_x;
               ctr_y_ff <= rd_y;
               ctr_z_ff <= rd_z;
            end
            SEL_UP: up_ff    <= dvec;
            SEL_DN: dn_ff    <= dvec;
            SEL_RT: rt_ff    <= dvec;
            SEL_LF: lf_ff    <= dvec;
            SEL_D0: dg_ff[0] <= dvec;
            SEL_D1: dg_ff[1] <= dvec;
            SEL_D2: dg_ff[2] <= dvec;
            SEL_D3: dg_ff[3] <= dvec;
            default: ;
         endcase
      end
   end

   // ---------------- cross products, one component per cycle
   vec_type              e1, e2, dg, va, vb;
   logic                 quad_en;
   logic signed [DW-1:0] fa1, fb1, fa2, fb2;
   logic signed [PW-1:0] p1_ff, p2_ff;
   logic                 pv_ff;
   axis_type             pax_ff;
   logic signed [ACC_W-1:0] acc_ff [3];

   always_comb begin
      e1 = rt_ff; e2 = dn_ff; dg = dg_ff[0]; quad_en = has_rt && has_dn;
      case (cmd.quad)
         QD_RT_DN: begin e1 = rt_ff; e2 = dn_ff; dg = dg_ff[0]; quad_en = has_rt && has_dn; end
         QD_DN_LF: begin e1 = dn_ff; e2 = lf_ff; dg = dg_ff[1]; quad_en = has_dn && has_lf; end
         QD_LF_UP: begin e1 = lf_ff; e2 = up_ff; dg = dg_ff[2]; quad_en = has_lf && has_up; end
         QD_UP_RT: begin e1 = up_ff; e2 = rt_ff; dg = dg_ff[3]; quad_en = has_up && has_rt; end
         default: quad_en = 1'b0;
      endcase
      va = e1; vb = e2;
      case (cmd.term)
         TERM_EDGES:   begin va = e1; vb = e2; end
         TERM_E1_DIAG: begin va = e1; vb = dg; end
         TERM_DIAG_E2: begin va = dg; vb = e2; end
         default:      begin va = e1; vb = e2; end
      endcase
      fa1 = va.y; fb1 = vb.z; fa2 = va.z; fb2 = vb.y;
      case (cmd.axis)
         AX_X: begin fa1 = va.y; fb1 = vb.z; fa2 = va.z; fb2 = vb.y; end
         AX_Y: begin fa1 = va.z; fb1 = vb.x; fa2 = va.x; fb2 = vb.z; end
         AX_Z: begin fa1 = va.x; fb1 = vb.y; fa2 = va.y; fb2 = vb.x; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= cmd.cross_issue && quad_en;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff  <= fa1 * fb1;
      p2_ff  <= fa2 * fb2;
      pax_ff <= cmd.axis;
      if (cmd.accept) begin
         for (int i = 0; i < 3; i++) acc_ff[i] <= '0;
      end else if (pv_ff) begin
         case (pax_ff)
            AX_X: acc_ff[0] <= acc_ff[0] + ACC_W'(p1_ff) - ACC_W'(p2_ff);
            AX_Y: acc_ff[1] <= acc_ff[1] + ACC_W'(p1_ff) - ACC_W'(p2_ff);
            AX_Z: acc_ff[2] <= acc_ff[2] + ACC_W'(p1_ff) - ACC_W'(p2_ff);
            default: ;
         endcase
      end
   end

   // ---------------- normalizing shift, one bit per cycle
   logic [MW-1:0] mag_ff [3];
   logic [MW-1:0] mag_max, mag_xy;
   logic          shift_right;

   assign mag_xy      = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
   assign mag_max     = (mag_ff[2] > mag_xy) ? mag_ff[2] : mag_xy;
   assign shift_right = (mag_max >> 30) != '0;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.norm_init) begin
            mag_ff[i] <= acc_ff[i][ACC_W-1] ? MW'(-acc_ff[i]) : MW'(acc_ff[i]);
         end else if (cmd.shift_step) begin
            mag_ff[i] <= shift_right ? (mag_ff[i] >> 1) : (mag_ff[i] << 1);
         end
      end
   end

   // ---------------- squared length and integer square root
   logic [59:0]     sq_ff [3];
   logic [61:0]     sumsq_ff;
   logic [SQ_W-1:0] rem_ff, res_ff, bit_ff, trial;
   logic            sqrt_ge;

   assign trial   = res_ff + bit_ff;
   assign sqrt_ge = rem_ff >= trial;

   always_ff @(posedge clock) begin
      if (cmd.sq_mul) begin
         for (int i = 0; i < 3; i++) sq_ff[i] <= mag_ff[i][29:0] * mag_ff[i][29:0];
      end
      if (cmd.sq_sum) begin
         sumsq_ff <= 62'(sq_ff[0]) + 62'(sq_ff[1]) + 62'(sq_ff[2]);
      end
      if (cmd.sqrt_init) begin
         rem_ff <= SQ_W'(sumsq_ff);
         res_ff <= '0;
         bit_ff <= SQ_W'(1) << 60;
      end else if (cmd.sqrt_step) begin
         if (sqrt_ge) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // ---------------- rounded division, three restoring lanes
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] drem_ff [3];
   logic [Q_W-1:0]   nlo_ff  [3];
   logic [Q_W-1:0]   quo_ff  [3];
   logic [NUM_W-1:0] num     [3];
   logic [LEN_W:0]   trem    [3];
   logic             dge     [3];

   assign len = res_ff[LEN_W-1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i]  = (NUM_W'(mag_ff[i][29:0]) << 14) + NUM_W'(len >> 1);
         trem[i] = {drem_ff[i], nlo_ff[i][Q_W-1]};
         dge[i]  = trem[i] >= {1'b0, len};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.div_init) begin
            drem_ff[i] <= LEN_W'(num[i][NUM_W-1:Q_W]);
            nlo_ff[i]  <= num[i][Q_W-1:0];
            quo_ff[i]  <= '0;
         end else if (cmd.div_step) begin
            drem_ff[i] <= dge[i] ? LEN_W'(trem[i] - {1'b0, len}) : trem[i][LEN_W-1:0];
            nlo_ff[i]  <= nlo_ff[i] << 1;
            quo_ff[i]  <= {quo_ff[i][Q_W-2:0], dge[i]};
         end
      end
   end

   // ---------------- result register
   logic              out_vld_ff;
   logic [NORM_W-1:0] out_n_ff [3];
   logic              out_deg_ff, out_rng_ff;
   logic [NORM_W-1:0] qv [3];
   logic              good;

   assign good = in_range && (type_ff == REQ_QUERY) && (mag_max != '0);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qv[i] = {1'b0, quo_ff[i]};
         if (acc_ff[i][ACC_W-1]) qv[i] = NORM_W'(-qv[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         for (int i = 0; i < 3; i++) out_n_ff[i] <= good ? qv[i] : '0;
         out_deg_ff <= in_range && (type_ff == REQ_QUERY) && (mag_max == '0);
         out_rng_ff <= !in_range;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign norm_x      = out_n_ff[0];
   assign norm_y      = out_n_ff[1];
   assign norm_z      = out_n_ff[2];
   assign degenerate  = out_deg_ff;
   assign range_error = out_rng_ff;

   assign sts.in_range  = in_range;
   assign sts.is_query  = type_ff == REQ_QUERY;
   assign sts.mag_zero  = mag_max == '0;
   assign sts.norm_done = (mag_max >> 29) == MW'(1);
   assign sts.out_free  = !out_vld_ff || rsp_ready;
endmodule
